// ===== rtl/tsmp_pkg.sv =====
package tsmp_pkg;

  // geometry and number formats
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COORD_FRAC = 16;
  localparam int COORD_BITS = 21;
  localparam int SZ_BITS    = 9;
  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS  = X_BITS + Y_BITS;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // scaled coordinate: size (unsigned, one sign bit added) times coord
  localparam int PROD_BITS  = COORD_BITS + SZ_BITS + 1;
  localparam int INT_BITS   = PROD_BITS - COORD_FRAC;
  localparam int CNT_BITS   = $clog2(INT_BITS);

  // blend weights and accumulators
  localparam int WT_BITS    = 2 * (COORD_FRAC + 1);
  localparam int ACC_BITS   = WT_BITS + 8;
  localparam int OUT_SHIFT  = 2 * COORD_FRAC - 8;
  localparam int CHAN_BITS  = 16;

  // work queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR   = $clog2(FIFO_DEPTH);

  // codes
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;
  localparam logic FILT_NEAREST = 1'b0;
  localparam logic FILT_LINEAR  = 1'b1;
  localparam logic WRAP_CLAMP   = 1'b0;
  localparam logic WRAP_REPEAT  = 1'b1;

  localparam int   PADDR_BITS   = 4;
  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_WRAP   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic                  filt;
    logic                  wrap;
    logic [SZ_BITS-1:0]    w;
    logic [SZ_BITS-1:0]    h;
  } cfg_t;

  typedef struct packed {
    logic                  op;
    logic                  filt;
    logic [X_BITS-1:0]     x0;
    logic [X_BITS-1:0]     x1;
    logic [Y_BITS-1:0]     y0;
    logic [Y_BITS-1:0]     y1;
    logic [COORD_FRAC-1:0] fi;
    logic [COORD_FRAC-1:0] fj;
    logic [31:0]           rgba;
  } cmd_t;

endpackage

// ===== rtl/tsmp_ifs.sv =====
interface tsmp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [7:0]                            texel_x;
  logic [7:0]                            texel_y;
  logic [31:0]                           texel_rgba;
  logic signed [tsmp_pkg::COORD_BITS-1:0] coord_s;
  logic signed [tsmp_pkg::COORD_BITS-1:0] coord_t;

  modport source (output valid, operation, texel_x, texel_y, texel_rgba, coord_s, coord_t,
                  input ready);
  modport sink   (input valid, operation, texel_x, texel_y, texel_rgba, coord_s, coord_t,
                  output ready);
endinterface

interface tsmp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/tsmp_fifo.sv =====
module tsmp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tsmp_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output tsmp_pkg::cmd_t  pop_data,
  output logic            nonempty
);

  tsmp_pkg::cmd_t                  mem_r [tsmp_pkg::FIFO_DEPTH];
  logic [tsmp_pkg::FIFO_PTR-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [tsmp_pkg::FIFO_PTR:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (tsmp_pkg::FIFO_PTR+1)'(tsmp_pkg::FIFO_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = wp_r + 1'b1;
    if (pop)  rp_nxt = rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ===== rtl/tsmp_front.sv =====
module tsmp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  tsmp_pkg::cfg_t  cfg,
  tsmp_in_if.sink         in_if,
  output logic            q_push,
  output tsmp_pkg::cmd_t  q_data,
  input  logic            q_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_PREP = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_FIX  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  localparam int SB = tsmp_pkg::SZ_BITS;
  localparam int IB = tsmp_pkg::INT_BITS;
  localparam int PB = tsmp_pkg::PROD_BITS;
  localparam int CF = tsmp_pkg::COORD_FRAC;

  logic [2:0]                                state_r, state_nxt;
  tsmp_pkg::cmd_t                            ent_r, ent_nxt;
  logic                                      wrap_r, wrap_nxt;
  logic signed [tsmp_pkg::COORD_BITS-1:0]    s_r, s_nxt, t_r, t_nxt;
  logic signed [PB-1:0]                      us_r, us_nxt, ut_r, ut_nxt;
  logic signed [IB-1:0]                      cx_r, cx_nxt, cy_r, cy_nxt;
  logic                                      incx_r, incx_nxt, incy_r, incy_nxt;
  logic [IB-1:0]                             magx_r, magx_nxt, magy_r, magy_nxt;
  logic [SB-1:0]                             remx_r, remx_nxt, remy_r, remy_nxt;
  logic [tsmp_pkg::CNT_BITS-1:0]             cnt_r, cnt_nxt;
  logic signed [IB-1:0]                      flx, fly, ncx, ncy;
  logic [CF-1:0]                             frx, fry;
  logic [2*SB-1:0]                           fixx, fixy;

  // one restoring division step: shift in a dividend bit, subtract size if it fits
  function automatic logic [SB-1:0] div_step(logic [SB-1:0] rem, logic b, logic [SB-1:0] sz);
    logic [SB:0] tr;
    tr = {rem, b};
    if (tr >= {1'b0, sz}) tr = tr - {1'b0, sz};
    return tr[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] clamp(logic signed [IB:0] v, logic [SB-1:0] sz);
    logic signed [IB:0] szs;
    logic [SB-1:0]      r;
    szs = $signed({{(IB+1-SB){1'b0}}, sz});
    if (v < 0)          r = '0;
    else if (v >= szs)  r = sz - 1'b1;
    else                r = v[SB-1:0];
    return r;
  endfunction

  // returns {hi, lo} wrapped indexes for one axis
  function automatic logic [2*SB-1:0] fix_axis(logic signed [IB-1:0] c, logic inc, logic wrap,
                                               logic [SB-1:0] rem, logic [SB-1:0] sz);
    logic signed [IB:0] ce;
    logic [SB-1:0]      lo, lo1, hi;
    ce = {c[IB-1], c};
    if (wrap == tsmp_pkg::WRAP_REPEAT) begin
      lo  = (c < 0 && rem != '0) ? sz - rem : rem;
      lo1 = lo + 1'b1;
      hi  = inc ? ((lo1 == sz) ? '0 : lo1) : lo;
    end else begin
      lo = clamp(ce, sz);
      hi = clamp(ce + $signed({{IB{1'b0}}, inc}), sz);
    end
    return {hi, lo};
  endfunction

  assign in_if.ready = (state_r == F_IDLE);
  assign q_push      = (state_r == F_PUSH) && !q_full;
  assign q_data      = ent_r;

  always_comb begin
    flx  = us_r[PB-1:CF];
    fly  = ut_r[PB-1:CF];
    frx  = us_r[CF-1:0];
    fry  = ut_r[CF-1:0];
    ncx  = (us_r[PB-1] && frx != '0) ? flx + 1'b1 : flx;
    ncy  = (ut_r[PB-1] && fry != '0) ? fly + 1'b1 : fly;
    fixx = fix_axis(cx_r, incx_r, wrap_r, remx_r, cfg.w);
    fixy = fix_axis(cy_r, incy_r, wrap_r, remy_r, cfg.h);
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    wrap_nxt  = wrap_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    us_nxt    = us_r;
    ut_nxt    = ut_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    incx_nxt  = incx_r;
    incy_nxt  = incy_r;
    magx_nxt  = magx_r;
    magy_nxt  = magy_r;
    remx_nxt  = remx_r;
    remy_nxt  = remy_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_if.valid) begin
          ent_nxt.op   = in_if.operation;
          ent_nxt.filt = cfg.filt;
          ent_nxt.x0   = in_if.texel_x;
          ent_nxt.y0   = in_if.texel_y;
          ent_nxt.rgba = in_if.texel_rgba;
          wrap_nxt     = cfg.wrap;
          s_nxt        = in_if.coord_s;
          t_nxt        = in_if.coord_t;
          state_nxt    = (in_if.operation == tsmp_pkg::OP_LOAD) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: begin
        us_nxt    = PB'($signed({1'b0, cfg.w}) * s_r);
        ut_nxt    = PB'($signed({1'b0, cfg.h}) * t_r);
        state_nxt = F_PREP;
      end
      F_PREP: begin
        if (ent_r.filt == tsmp_pkg::FILT_LINEAR) begin
          cx_nxt     = flx;
          cy_nxt     = fly;
          incx_nxt   = (frx != '0);
          incy_nxt   = (fry != '0);
          ent_nxt.fi = frx;
          ent_nxt.fj = fry;
        end else begin
          cx_nxt     = ncx;
          cy_nxt     = ncy;
          incx_nxt   = 1'b0;
          incy_nxt   = 1'b0;
          ent_nxt.fi = '0;
          ent_nxt.fj = '0;
        end
        magx_nxt  = cx_nxt[IB-1] ? IB'(-cx_nxt) : IB'(cx_nxt);
        magy_nxt  = cy_nxt[IB-1] ? IB'(-cy_nxt) : IB'(cy_nxt);
        remx_nxt  = '0;
        remy_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = (wrap_r == tsmp_pkg::WRAP_REPEAT) ? F_DIV : F_FIX;
      end
      F_DIV: begin
        remx_nxt = div_step(remx_r, magx_r[IB-1], cfg.w);
        remy_nxt = div_step(remy_r, magy_r[IB-1], cfg.h);
        magx_nxt = magx_r << 1;
        magy_nxt = magy_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == tsmp_pkg::CNT_BITS'(IB - 1)) state_nxt = F_FIX;
      end
      F_FIX: begin
        ent_nxt.x0 = fixx[tsmp_pkg::X_BITS-1:0];
        ent_nxt.x1 = fixx[SB +: tsmp_pkg::X_BITS];
        ent_nxt.y0 = fixy[tsmp_pkg::Y_BITS-1:0];
        ent_nxt.y1 = fixy[SB +: tsmp_pkg::Y_BITS];
        state_nxt  = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    wrap_r <= wrap_nxt;
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    us_r   <= us_nxt;
    ut_r   <= ut_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    incx_r <= incx_nxt;
    incy_r <= incy_nxt;
    magx_r <= magx_nxt;
    magy_r <= magy_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// ===== rtl/tsmp_back.sv =====
module tsmp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  tsmp_pkg::cmd_t  q_data,
  output logic            q_pop,
  tsmp_out_if.source      out_if
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_FETCH = 2'd1;
  localparam logic [1:0] B_LAST  = 2'd2;
  localparam logic [1:0] B_OUT   = 2'd3;

  localparam int CF = tsmp_pkg::COORD_FRAC;
  localparam int AB = tsmp_pkg::ACC_BITS;

  logic [1:0]                        state_r, state_nxt;
  tsmp_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [1:0]                        step_r, step_nxt;
  logic                              acc_en_r;
  logic [tsmp_pkg::WT_BITS-1:0]      wt_r;
  logic [31:0]                       rd_r;
  logic [AB-1:0]                     acc_r [4];
  logic [AB-1:0]                     acc_nxt [4];
  logic [tsmp_pkg::CHAN_BITS-1:0]    chan_r [4];
  logic                              ovalid_r, ovalid_nxt;
  logic                              load_out;
  logic                              mem_we;
  logic [tsmp_pkg::ADDR_BITS-1:0]    mem_addr;
  logic [CF:0]                       wa, wb;
  logic [31:0]                       mem [tsmp_pkg::MEM_DEPTH];

  assign q_pop = (state_r == B_IDLE) && q_nonempty;
  assign mem_we = q_pop && (q_data.op == tsmp_pkg::OP_LOAD);
  assign load_out = (state_r == B_OUT) && (!ovalid_r || out_if.ready);

  // fetch order: step bit 1 picks the upper column, bit 0 the upper row
  always_comb begin
    if (state_r == B_FETCH) begin
      mem_addr = {step_r[0] ? cmd_r.y1 : cmd_r.y0, step_r[1] ? cmd_r.x1 : cmd_r.x0};
    end else begin
      mem_addr = {q_data.y0, q_data.x0};
    end
    wa = step_r[1] ? {1'b0, cmd_r.fi} : (CF+1)'(1 << CF) - {1'b0, cmd_r.fi};
    wb = step_r[0] ? {1'b0, cmd_r.fj} : (CF+1)'(1 << CF) - {1'b0, cmd_r.fj};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= q_data.rgba;
    else        rd_r <= mem[mem_addr];
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc_nxt[k] = acc_r[k];
      if (q_pop) acc_nxt[k] = '0;
      else if (acc_en_r)
        acc_nxt[k] = acc_r[k] + AB'({{(AB-8){1'b0}}, rd_r[8*k +: 8]} * {8'd0, wt_r});
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_if.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop && q_data.op == tsmp_pkg::OP_SAMPLE) begin
          cmd_nxt   = q_data;
          step_nxt  = '0;
          state_nxt = B_FETCH;
        end
      end
      B_FETCH: begin
        step_nxt = step_r + 1'b1;
        if (cmd_r.filt == tsmp_pkg::FILT_NEAREST || step_r == 2'd3) state_nxt = B_LAST;
      end
      B_LAST: state_nxt = B_OUT;
      B_OUT: begin
        if (load_out) begin
          ovalid_nxt = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
      acc_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      acc_en_r <= (state_r == B_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    step_r <= step_nxt;
    wt_r   <= tsmp_pkg::WT_BITS'(wa * wb);
    for (int k = 0; k < 4; k++) begin
      acc_r[k] <= acc_nxt[k];
      if (load_out) chan_r[k] <= acc_r[k][tsmp_pkg::OUT_SHIFT +: tsmp_pkg::CHAN_BITS];
    end
  end

  assign out_if.valid = ovalid_r;
  assign out_if.red   = chan_r[0];
  assign out_if.green = chan_r[1];
  assign out_if.blue  = chan_r[2];
  assign out_if.alpha = chan_r[3];

endmodule

// ===== rtl/texture_sampler_core.sv =====
// Bilinear texture sampler with an on-chip 256x256 RGBA8 texel store.
// in_if: one beat is either a texel load (texel_x, texel_y, texel_rgba) or
//   a sample (coord_s, coord_t, signed fixed point with 16 fraction bits).
//   Loads give no result beat; each sample gives exactly one on out_if.
// out_if: red/green/blue/alpha in byte scale Q8.8, truncated.
// APB port: filter_mode @0x0, wrap_mode @0x4, tex_width @0x8,
//   tex_height @0xC; write only while the block is idle. pready is tied high.
// Front end: a sample passes MUL, PREP, FIX, PUSH; repeat mode adds DIV
//   (15-step restoring divider per axis for the modulo); loads go to PUSH.
// Back end: one single-port texel RAM, one fetch per cycle; a nearest
//   sample makes one fetch, a bilinear sample four, a load one write.
// A 4-entry queue sits between front and back so each stalls on its own.
// Reset: registers go to nearest, clamp, 256x256; queue and output empty.
//   The texel store is not cleared; unloaded texels read as garbage.
// If out_if.ready stays low, one result waits in the output register,
//   the back end finishes the next item and holds, the queue fills, then
//   in_if.ready drops.
module texture_sampler_core (
  input  logic                           clk,
  input  logic                           rst_n,
  tsmp_in_if.sink                        in_if,
  tsmp_out_if.source                     out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsmp_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int SB = tsmp_pkg::SZ_BITS;

  // raw register values as written
  logic          filt_r, filt_nxt;
  logic          wrap_r, wrap_nxt;
  logic [SB-1:0] width_r, width_nxt;
  logic [SB-1:0] height_r, height_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  tsmp_pkg::cfg_t cfg;
  logic           q_push, q_full, q_pop, q_nonempty;
  tsmp_pkg::cmd_t q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    filt_nxt   = filt_r;
    wrap_nxt   = wrap_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (reg_idx)
        tsmp_pkg::REG_FILTER: filt_nxt   = pwdata[0];
        tsmp_pkg::REG_WRAP:   wrap_nxt   = pwdata[0];
        tsmp_pkg::REG_WIDTH:  width_nxt  = pwdata[SB-1:0];
        tsmp_pkg::REG_HEIGHT: height_nxt = pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= tsmp_pkg::FILT_NEAREST;
      wrap_r   <= tsmp_pkg::WRAP_CLAMP;
      width_r  <= SB'(tsmp_pkg::MAX_WIDTH);
      height_r <= SB'(tsmp_pkg::MAX_HEIGHT);
    end else begin
      filt_r   <= filt_nxt;
      wrap_r   <= wrap_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsmp_pkg::REG_FILTER: prdata = {31'd0, filt_r};
      tsmp_pkg::REG_WRAP:   prdata = {31'd0, wrap_r};
      tsmp_pkg::REG_WIDTH:  prdata = {{(32-SB){1'b0}}, width_r};
      tsmp_pkg::REG_HEIGHT: prdata = {{(32-SB){1'b0}}, height_r};
      default:              prdata = '0;
    endcase
  end

  // effective size: zero acts as one, above the store size acts as the maximum
  always_comb begin
    cfg.filt = filt_r;
    cfg.wrap = wrap_r;
    if (width_r == '0)                          cfg.w = SB'(1);
    else if (width_r > SB'(tsmp_pkg::MAX_WIDTH)) cfg.w = SB'(tsmp_pkg::MAX_WIDTH);
    else                                        cfg.w = width_r;
    if (height_r == '0)                           cfg.h = SB'(1);
    else if (height_r > SB'(tsmp_pkg::MAX_HEIGHT)) cfg.h = SB'(tsmp_pkg::MAX_HEIGHT);
    else                                          cfg.h = height_r;
  end

  tsmp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_if  (in_if),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  tsmp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .nonempty  (q_nonempty)
  );

  tsmp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_if     (out_if)
  );

endmodule
